>>> sv/cht_pkg.sv
// Shared types and constants for the chained hash table engine.
// No dependencies.
package cht_pkg;

  localparam logic [63:0] MUL_M   = 64'hc6a4a7935bd1e995;
  localparam int          SHIFT_R = 47;
  localparam logic [63:0] SEED    = 64'h8445d61a4e774912;
  // initial hash state for an 8-byte key: seed ^ (len * m)
  localparam logic [63:0] HASH_INIT = SEED ^ (MUL_M << 3);

  localparam int SLOT_W = 10;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_LOAD,
    S_INS,
    S_HEAD,
    S_FETCH,
    S_CMP,
    S_UNLINK,
    S_FREE,
    S_RESP
  } state_t;

endpackage

>>> sv/cht_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on cht_pkg.
interface cht_in_if import cht_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key;
  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface cht_out_if import cht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

>>> sv/chained_hash_table_engine_core.sv
// Channel | Dir | Payload          | Handshake
// in_if   | in  | req_type, key    | valid/ready
// out_if  | out | status, slot     | valid/ready
//
// One request at a time. Hashing runs on the shared multiplier.
// After hashing, an insert links a free slot at the bucket head; a lookup walks
// the chain link by link, and a remove hit then adds the unlink writes.
// After reset a clearing pass over all 2^INDEX_BITS buckets runs before in_if.ready.
// The result waits in an output register; a stalled output delays the next
// request only until that register frees.
module chained_hash_table_engine_core import cht_pkg::*; #(
  parameter int INDEX_BITS = 10
) (
  input logic      clk,
  input logic      rst_n,
  cht_in_if.sink   in_if,
  cht_out_if.source out_if
);
  localparam int          IB      = INDEX_BITS;
  localparam int          PW      = IB + 1;
  localparam int          N       = 1 << IB;
  localparam logic [PW-1:0] END_PTR = {1'b1, {IB{1'b0}}};

  state_t          state_r, state_nxt;
  logic [IB-1:0]   clr_r, clr_nxt;
  req_t            req_r, req_nxt;
  logic [63:0]     key_r, key_nxt;
  logic [IB-1:0]   bucket_r, bucket_nxt;
  logic [PW-1:0]   free_cnt_r, free_cnt_nxt;
  logic [PW-1:0]   cur_r, cur_nxt, prev_r, prev_nxt, link_r, link_nxt;
  logic [PW-1:0]   steps_r, steps_nxt;
  status_t         res_st_r, res_st_nxt;
  logic [IB-1:0]   res_slot_r, res_slot_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_st_r, out_st_nxt;
  logic [IB-1:0]   out_slot_r, out_slot_nxt;

  logic            hash_start, hash_done;
  logic [IB-1:0]   hash_bucket;

  logic            bh_we, fs_we, sk_we, sn_we;
  logic [IB-1:0]   bh_wa, fs_wa, sk_wa, sn_wa, fs_ra;
  logic [PW-1:0]   bh_wd, sn_wd, bh_rd, sn_rd;
  logic [IB-1:0]   fs_wd, fs_rd;
  logic [63:0]     sk_rd;
  logic [PW-1:0]   fs_top;
  logic [SLOT_W+IB-1:0] slot_ext;

  cht_hash #(.INDEX_BITS(IB)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .key(key_nxt),
    .done(hash_done), .bucket(hash_bucket)
  );

  cht_ram #(.WIDTH(PW), .DEPTH(N)) u_head (
    .clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd),
    .raddr(bucket_r), .rdata(bh_rd)
  );
  cht_ram #(.WIDTH(IB), .DEPTH(N)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
    .raddr(fs_ra), .rdata(fs_rd)
  );
  cht_ram #(.WIDTH(64), .DEPTH(N)) u_key (
    .clk(clk), .we(sk_we), .waddr(sk_wa), .wdata(key_r),
    .raddr(cur_r[IB-1:0]), .rdata(sk_rd)
  );
  cht_ram #(.WIDTH(PW), .DEPTH(N)) u_next (
    .clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd),
    .raddr(cur_r[IB-1:0]), .rdata(sn_rd)
  );

  assign fs_top = free_cnt_r - PW'(1);
  assign fs_ra  = fs_top[IB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_cnt_r  <= PW'(N);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    bucket_r   <= bucket_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    link_r     <= link_nxt;
    steps_r    <= steps_nxt;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    out_st_r   <= out_st_nxt;
    out_slot_r <= out_slot_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    bucket_nxt    = bucket_r;
    free_cnt_nxt  = free_cnt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    link_nxt      = link_r;
    steps_nxt     = steps_r;
    res_st_nxt    = res_st_r;
    res_slot_nxt  = res_slot_r;
    out_st_nxt    = out_st_r;
    out_slot_nxt  = out_slot_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    in_if.ready   = 1'b0;
    hash_start    = 1'b0;
    bh_we = 1'b0; bh_wa = bucket_r;      bh_wd = END_PTR;
    fs_we = 1'b0; fs_wa = clr_r;         fs_wd = ~clr_r;
    sk_we = 1'b0; sk_wa = fs_rd;
    sn_we = 1'b0; sn_wa = cur_r[IB-1:0]; sn_wd = END_PTR;

    unique case (state_r)
      S_CLEAR: begin
        // empty every bucket and stack every slot, top of stack is slot 0
        bh_we   = 1'b1;
        bh_wa   = clr_r;
        fs_we   = 1'b1;
        clr_nxt = clr_r + IB'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          req_nxt    = req_t'(in_if.req_type);
          key_nxt    = in_if.key;
          hash_start = 1'b1;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_nxt = hash_bucket;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        if (req_r == REQ_INSERT) begin
          if (free_cnt_r == '0) begin
            res_st_nxt   = ST_FULL;
            res_slot_nxt = '0;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_INS;
          end
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_INS: begin
        sk_we        = 1'b1;
        sn_we        = 1'b1;
        sn_wa        = fs_rd;
        sn_wd        = bh_rd;
        bh_we        = 1'b1;
        bh_wd        = {1'b0, fs_rd};
        free_cnt_nxt = fs_top;
        res_st_nxt   = ST_OK;
        res_slot_nxt = fs_rd;
        state_nxt    = S_RESP;
      end
      S_HEAD: begin
        cur_nxt   = bh_rd;
        prev_nxt  = END_PTR;
        steps_nxt = '0;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (cur_r[IB] || steps_r == PW'(N)) begin
          res_st_nxt   = ST_MISSING;
          res_slot_nxt = '0;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sk_rd == key_r) begin
          if (req_r == REQ_REMOVE) begin
            link_nxt  = sn_rd;
            state_nxt = S_UNLINK;
          end else begin
            res_st_nxt   = ST_OK;
            res_slot_nxt = cur_r[IB-1:0];
            state_nxt    = S_RESP;
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = sn_rd;
          steps_nxt = steps_r + PW'(1);
          state_nxt = S_FETCH;
        end
      end
      S_UNLINK: begin
        if (prev_r[IB]) begin
          bh_we = 1'b1;
          bh_wd = link_r;
        end else begin
          sn_we = 1'b1;
          sn_wa = prev_r[IB-1:0];
          sn_wd = link_r;
        end
        state_nxt = S_FREE;
      end
      S_FREE: begin
        sn_we = 1'b1;
        if (!free_cnt_r[IB]) begin
          fs_we        = 1'b1;
          fs_wa        = free_cnt_r[IB-1:0];
          fs_wd        = cur_r[IB-1:0];
          free_cnt_nxt = free_cnt_r + PW'(1);
        end
        res_st_nxt   = ST_OK;
        res_slot_nxt = cur_r[IB-1:0];
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_slot_nxt  = res_slot_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign slot_ext      = {{SLOT_W{1'b0}}, out_slot_r};
  assign out_if.valid  = out_valid_r;
  assign out_if.status = out_st_r;
  assign out_if.slot   = slot_ext[SLOT_W-1:0];
endmodule

>>> sv/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/cht_hash.sv
// Iterative MurmurHash64A of one 64-bit key on a shared 32x32 multiplier.
// Depends on cht_pkg. Four 64-bit multiplies.
module cht_hash import cht_pkg::*; #(
  parameter int INDEX_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           key,
  output logic                  done,
  output logic [INDEX_BITS-1:0] bucket
);
  logic [63:0] x_r, acc_r, prod_r;
  logic [1:0]  ph_r, mi_r;
  logic        run_r, done_r;
  logic [31:0] op_a, op_b;
  logic [63:0] full;

  always_comb begin
    op_a = (ph_r == 2'd1) ? x_r[63:32] : x_r[31:0];
    op_b = (ph_r == 2'd2) ? MUL_M[63:32] : MUL_M[31:0];
    full = acc_r + {prod_r[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
      mi_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= '0;
        mi_r  <= '0;
        x_r   <= key;
      end else if (run_r) begin
        prod_r <= op_a * op_b;
        ph_r   <= ph_r + 2'd1;
        unique case (ph_r)
          2'd0: ;
          2'd1: acc_r <= prod_r;
          2'd2: acc_r <= full;
          2'd3: begin
            // second multiply folds into the hash state, the rest xorshift
            if (mi_r == 2'd1) begin
              x_r <= full ^ HASH_INIT;
            end else begin
              x_r <= full ^ (full >> SHIFT_R);
            end
            mi_r <= mi_r + 2'd1;
            if (mi_r == 2'd3) begin
              run_r  <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign done   = done_r;
  assign bucket = x_r[INDEX_BITS-1:0];
endmodule

>>> sv/cht_checker.sv
// Port-level checks for the chained hash table engine, bound to the top.
// Depends on cht_pkg.
module cht_checker import cht_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_status,
  input logic [SLOT_W-1:0] out_slot
);
  // one request in flight: ready drops right after an item is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_RSVD)
    else $error("reserved status code");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_slot == '0)
    else $error("nonzero slot on failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result changed while stalled");
endmodule

bind chained_hash_table_engine_core cht_checker u_cht_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_status(out_if.status), .out_slot(out_if.slot)
);
